// ----- rtl/gbp_pkg.sv -----
// Shared types and constants for the gshare branch predictor.
// No dependencies; the top level, the front end and the back end import this package.
package gbp_pkg;

    localparam int TAG_W       = 64;
    localparam int CTR_W       = 2;
    localparam int ENTRY_W     = TAG_W + CTR_W;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int IBITS_W     = 4;
    localparam int HASH_W      = 2;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CTR_W-1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX        = 2'd3;
    localparam logic [CTR_W-1:0] CTR_MIN        = 2'd0;

    localparam logic [IBITS_W-1:0] INDEX_BITS_RESET = 4'd14;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HASH_MODE  = 1'b1;

    localparam logic [HASH_W-1:0] HASH_XOR_A2 = 2'd0;
    localparam logic [HASH_W-1:0] HASH_XOR_A0 = 2'd1;
    localparam logic [HASH_W-1:0] HASH_ADD_A2 = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_back_state;

    typedef struct packed {
        logic [TAG_W-1:0] addr;
        logic             taken;
        logic             add_op;
    } t_q_entry;

endpackage

// ----- rtl/gshare_branch_predictor_unit.sv -----
// Top level of the gshare branch predictor: configuration registers, index mask,
// front end with request queue and back end with the counter/tag table.
// Uses gbp_pkg, gbp_front, gbp_back.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   in       | i_in_valid / o_in_ready   | i_branch_address, i_outcome_taken
//   out      | o_out_valid / i_out_ready | o_predict_taken, o_tag_conflict, o_mispredicted
//   cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each branch passes through the back end in order: ST_IDLE reads the table entry,
// ST_LOOKUP reports and writes it back; no new request is taken until that write-back.
// After reset the table is swept once over its 2**MAX_INDEX_BITS entries (16384 by default),
// with o_in_ready low; configuration writes are taken throughout.
// A stalled output holds the back end; the two-entry queue keeps taking requests until full.
module gshare_branch_predictor_unit #(
    parameter int MAX_INDEX_BITS = 14
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [gbp_pkg::TAG_W-1:0]        i_branch_address,
    input  logic                             i_outcome_taken,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_predict_taken,
    output logic                             o_tag_conflict,
    output logic                             o_mispredicted,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gbp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gbp_pkg::*;

    logic [IBITS_W-1:0]        r_index_bits;
    logic [HASH_W-1:0]         r_hash_mode;
    logic [MAX_INDEX_BITS-1:0] w_index_mask;
    logic                      w_q_valid, w_q_pop, w_clearing;
    t_q_entry                  w_q_entry;
    logic [MAX_INDEX_BITS-1:0] w_q_abits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits <= INDEX_BITS_RESET;
            r_hash_mode  <= HASH_XOR_A2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INDEX_BITS: r_index_bits <= i_cfg_data;
                CFG_HASH_MODE:  r_hash_mode  <= i_cfg_data[HASH_W-1:0];
                default: ;
            endcase
        end
    end

    // Index widths beyond the table saturate to the full table.
    always_comb begin
        if (int'(r_index_bits) >= MAX_INDEX_BITS) begin
            w_index_mask = '1;
        end else begin
            w_index_mask = ~({MAX_INDEX_BITS{1'b1}} << r_index_bits);
        end
    end

    gbp_front #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_branch_address (i_branch_address),
        .i_outcome_taken  (i_outcome_taken),
        .i_hash_mode      (r_hash_mode),
        .i_clearing       (w_clearing),
        .o_q_valid        (w_q_valid),
        .i_q_pop          (w_q_pop),
        .o_q_entry        (w_q_entry),
        .o_q_abits        (w_q_abits)
    );

    gbp_back #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_index_mask    (w_index_mask),
        .i_q_valid       (w_q_valid),
        .o_q_pop         (w_q_pop),
        .i_q_entry       (w_q_entry),
        .i_q_abits       (w_q_abits),
        .o_clearing      (w_clearing),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_predict_taken (o_predict_taken),
        .o_tag_conflict  (o_tag_conflict),
        .o_mispredicted  (o_mispredicted)
    );
endmodule

// ----- rtl/gbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gbp_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/gbp_front.sv -----
// Front end: takes branch requests, picks the address bits for the hash mode
// and holds them in a two-entry queue for the back end. Uses gbp_pkg.
module gbp_front #(
    parameter int MAX_INDEX_BITS = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [gbp_pkg::TAG_W-1:0]    i_branch_address,
    input  logic                         i_outcome_taken,
    input  logic [gbp_pkg::HASH_W-1:0]   i_hash_mode,
    input  logic                         i_clearing,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output gbp_pkg::t_q_entry            o_q_entry,
    output logic [MAX_INDEX_BITS-1:0]    o_q_abits
);
    import gbp_pkg::*;

    t_q_entry                  r_q_entry [QDEPTH];
    logic [MAX_INDEX_BITS-1:0] r_q_abits [QDEPTH];
    logic [QPTR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]         r_count, n_count;
    logic                      w_push;
    t_q_entry                  w_entry;
    logic [MAX_INDEX_BITS-1:0] w_abits;

    assign o_in_ready = (r_count != QCNT_W'(QDEPTH)) && !i_clearing;
    assign w_push     = i_in_valid && o_in_ready;

    always_comb begin
        w_entry.addr   = i_branch_address;
        w_entry.taken  = i_outcome_taken;
        w_entry.add_op = 1'b0;
        w_abits        = i_branch_address[MAX_INDEX_BITS+1:2];
        unique case (i_hash_mode)
            HASH_XOR_A0: w_abits = i_branch_address[MAX_INDEX_BITS-1:0];
            HASH_ADD_A2: w_entry.add_op = 1'b1;
            default: w_abits = i_branch_address[MAX_INDEX_BITS+1:2];
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (w_push && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_entry[r_wr_ptr] <= w_entry;
            r_q_abits[r_wr_ptr] <= w_abits;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_entry = r_q_entry[r_rd_ptr];
    assign o_q_abits = r_q_abits[r_rd_ptr];
endmodule

// ----- rtl/gbp_back.sv -----
// Back end: clears the table after reset, then hashes each queued branch with
// the global history, reads the entry, reports and writes it back.
// Uses gbp_pkg and gbp_ram.
module gbp_back #(
    parameter int MAX_INDEX_BITS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [MAX_INDEX_BITS-1:0]  i_index_mask,
    input  logic                       i_q_valid,
    output logic                       o_q_pop,
    input  gbp_pkg::t_q_entry          i_q_entry,
    input  logic [MAX_INDEX_BITS-1:0]  i_q_abits,
    output logic                       o_clearing,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_predict_taken,
    output logic                       o_tag_conflict,
    output logic                       o_mispredicted
);
    import gbp_pkg::*;

    localparam int DEPTH = 1 << MAX_INDEX_BITS;

    t_back_state               r_state, n_state;
    logic [MAX_INDEX_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [MAX_INDEX_BITS-1:0] r_hist, n_hist;
    logic [MAX_INDEX_BITS-1:0] r_idx, n_idx;
    logic [TAG_W-1:0]          r_addr, n_addr;
    logic                      r_taken, n_taken;
    logic                      r_out_valid, n_out_valid;
    logic                      r_pred, n_pred;
    logic                      r_conf, n_conf;
    logic                      r_misp, n_misp;

    logic                      w_we, w_re;
    logic [MAX_INDEX_BITS-1:0] w_waddr, w_raddr, w_hash;
    logic [ENTRY_W-1:0]        w_wdata, w_rdata;
    logic [CTR_W-1:0]          w_ctr, w_ctr_next;
    logic                      w_out_free;

    gbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_hash = i_q_entry.add_op ? (i_q_abits + r_hist) : (i_q_abits ^ r_hist);
    assign w_ctr  = w_rdata[ENTRY_W-1:TAG_W];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_taken) begin
            w_ctr_next = (w_ctr == CTR_MAX) ? CTR_MAX : w_ctr + 1'b1;
        end else begin
            w_ctr_next = (w_ctr == CTR_MIN) ? CTR_MIN : w_ctr - 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_hist      = r_hist;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_taken     = r_taken;
        n_pred      = r_pred;
        n_conf      = r_conf;
        n_misp      = r_misp;
        n_out_valid = r_out_valid && !i_out_ready;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = {w_ctr_next, r_addr};
        w_re        = 1'b0;
        w_raddr     = w_hash & i_index_mask;
        o_q_pop     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = {CTR_WEAK_TAKEN, {TAG_W{1'b0}}};
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    w_re    = 1'b1;
                    o_q_pop = 1'b1;
                    n_idx   = w_raddr;
                    n_addr  = i_q_entry.addr;
                    n_taken = i_q_entry.taken;
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // Read data holds while the result register is still occupied.
                if (w_out_free) begin
                    w_we        = 1'b1;
                    n_pred      = w_ctr[1];
                    n_conf      = (w_rdata[TAG_W-1:0] != r_addr);
                    n_misp      = w_ctr[1] ^ r_taken;
                    n_out_valid = 1'b1;
                    n_hist      = MAX_INDEX_BITS'({r_hist, r_taken});
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_hist      <= n_hist;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_addr  <= n_addr;
        r_taken <= n_taken;
        r_pred  <= n_pred;
        r_conf  <= n_conf;
        r_misp  <= n_misp;
    end

    assign o_clearing      = (r_state == ST_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_predict_taken = r_pred;
    assign o_tag_conflict  = r_conf;
    assign o_mispredicted  = r_misp;
endmodule

// ----- rtl/gbp_checker.sv -----
// Port-level checks for the gshare branch predictor, bound to the top level.
// Depends only on the top level's ports.
module gbp_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_predict_taken,
    input logic o_tag_conflict,
    input logic o_mispredicted
);
    localparam int PEND_W = 3;

    logic [PEND_W-1:0] r_pend;
    logic              w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Requests taken whose results are not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_in_acc && w_out_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_predict_taken) &&
        $stable(o_tag_conflict) && $stable(o_mispredicted))
        else $error("stalled result changed");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("block active right after reset");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != '0)
        else $error("result shown without a pending request");
endmodule

bind gshare_branch_predictor_unit gbp_props u_gbp_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_predict_taken (o_predict_taken),
    .o_tag_conflict  (o_tag_conflict),
    .o_mispredicted  (o_mispredicted)
);
